/* hw/rtl/lfu_pkg.sv */
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 5;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // search beat handed from cell to cell
  typedef struct packed {
    logic               act;
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  wdata;
    logic               hit;
    logic [DATA_W-1:0]  hit_data;
    logic [COUNT_W-1:0] hit_cnt;
    logic               vic_ok;
    logic [COUNT_W-1:0] vic_cnt;
    logic [STAMP_W-1:0] vic_stamp;
    logic               free_ok;
  } probe_t;

  // update broadcast from the controller to all cells
  typedef struct packed {
    logic               en;
    logic               evict;
    logic               ins;
    logic               upd_data;
    logic               upd_cnt;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

/* hw/rtl/lfu_key_value_cache.sv */
`timescale 1ns / 1ps
// LFU key/value cache. Assert start with a get or set request while busy is
// low; a request is carried by a search beat that walks the row of entry
// cells one cell per clock before the update cycle. A get returns one
// result on out_valid in the same cycle in which busy drops; it must be
// taken then, as the receiver cannot stall. A set returns nothing.
module lfu_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic signed [31:0]        in_lookup_key,
  input  logic signed [63:0]        in_write_value,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic signed [63:0]        out_read_value,
  input  logic                      cfg_we,
  input  logic [4:0]                cfg_wdata
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW0 = $clog2(ENTRIES + 1);
  localparam int OW = (OW0 > CAP_W) ? OW0 : CAP_W;

  probe_t        p [ENTRIES+1];
  logic [IW-1:0] hi [ENTRIES+1];
  logic [IW-1:0] vi [ENTRIES+1];
  logic [IW-1:0] fi [ENTRIES+1];

  state_t state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [STAMP_W-1:0] sc_r, sc_nxt;
  logic               ov_r, ov_nxt, oh_r, oh_nxt;
  logic [DATA_W-1:0]  od_r, od_nxt;
  logic [OW-1:0]      eff_cap;
  upd_t               upd;
  logic [IW-1:0]      ev_idx, wr_idx;
  logic               accept, done, need_ev;
  probe_t             tl;

  assign accept = start && (state_r == ST_IDLE);
  assign tl     = p[ENTRIES];
  assign done   = (state_r == ST_SCAN) && tl.act;

  always_comb begin
    p[0]           = '0;
    p[0].act       = accept;
    p[0].mode      = in_mode;
    p[0].key       = in_lookup_key;
    p[0].wdata     = in_write_value;
    hi[0]          = '0;
    vi[0]          = '0;
    fi[0]          = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .p_in(p[g]), .hit_idx_in(hi[g]), .vic_idx_in(vi[g]), .free_idx_in(fi[g]),
      .p_out(p[g+1]), .hit_idx_out(hi[g+1]), .vic_idx_out(vi[g+1]),
      .free_idx_out(fi[g+1]),
      .upd(upd), .ev_idx(ev_idx), .wr_idx(wr_idx)
    );
  end

  always_comb begin
    if (cap_r == '0) eff_cap = OW'(1);
    else if (OW'(cap_r) > OW'(ENTRIES)) eff_cap = OW'(ENTRIES);
    else eff_cap = OW'(cap_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    upd      = '0;
    ev_idx   = vi[ENTRIES];
    wr_idx   = hi[ENTRIES];
    need_ev  = (occ_r >= eff_cap);
    occ_nxt  = occ_r;
    sc_nxt   = sc_r;
    ov_nxt   = 1'b0;
    oh_nxt   = oh_r;
    od_nxt   = od_r;
    upd.key  = tl.key;
    upd.data = tl.wdata;
    upd.stamp = sc_r;
    upd.count = tl.hit_cnt + COUNT_W'(1);
    if (done) begin
      if (tl.hit) begin
        upd.en       = 1'b1;
        upd.upd_data = (tl.mode == MODE_SET);
        if (tl.hit_cnt != '1) begin
          upd.upd_cnt = 1'b1;
          sc_nxt      = sc_r + STAMP_W'(1);
        end
      end else if (tl.mode == MODE_SET) begin
        upd.en       = 1'b1;
        upd.ins      = 1'b1;
        upd.upd_data = 1'b1;
        upd.upd_cnt  = 1'b1;
        upd.count    = COUNT_W'(1);
        sc_nxt       = sc_r + STAMP_W'(1);
        // lowest free slot after the eviction
        if (need_ev && tl.vic_ok) begin
          upd.evict = 1'b1;
          wr_idx = (tl.free_ok && fi[ENTRIES] < vi[ENTRIES]) ? fi[ENTRIES] : vi[ENTRIES];
        end else begin
          wr_idx  = fi[ENTRIES];
          occ_nxt = occ_r + OW'(1);
        end
      end
      if (tl.mode == MODE_GET) begin
        ov_nxt = 1'b1;
        oh_nxt = tl.hit;
        od_nxt = tl.hit ? tl.hit_data : '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= CAP_W'(16);
      occ_r   <= '0;
      sc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      sc_r    <= sc_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
    oh_r <= oh_nxt;
    od_r <= od_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_hit        = oh_r;
  assign out_read_value = od_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request did not go busy");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_miss_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == '1) else $error("miss value");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES)) else $error("occupancy overflow");

endmodule

/* hw/rtl/lfu_cell.sv */
`timescale 1ns / 1ps
module lfu_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lfu_pkg::probe_t p_in,
  input  logic [IW-1:0] hit_idx_in,
  input  logic [IW-1:0] vic_idx_in,
  input  logic [IW-1:0] free_idx_in,
  output lfu_pkg::probe_t p_out,
  output logic [IW-1:0] hit_idx_out,
  output logic [IW-1:0] vic_idx_out,
  output logic [IW-1:0] free_idx_out,
  input  lfu_pkg::upd_t upd,
  input  logic [IW-1:0] ev_idx,
  input  logic [IW-1:0] wr_idx
);
  import lfu_pkg::*;

  logic               valid_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  data_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [STAMP_W-1:0] stamp_r;

  probe_t        p_nxt, p_r;
  logic [IW-1:0] hit_idx_nxt, vic_idx_nxt, free_idx_nxt;
  logic [IW-1:0] hit_idx_r, vic_idx_r, free_idx_r;
  logic          is_hit, is_vic, is_free;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  assign is_hit  = valid_r && !p_in.hit && (key_r == p_in.key);
  assign is_vic  = valid_r && (!p_in.vic_ok || (cnt_r < p_in.vic_cnt) ||
                   ((cnt_r == p_in.vic_cnt) && (stamp_r < p_in.vic_stamp)));
  assign is_free = !valid_r && !p_in.free_ok;

  always_comb begin
    p_nxt        = p_in;
    hit_idx_nxt  = hit_idx_in;
    vic_idx_nxt  = vic_idx_in;
    free_idx_nxt = free_idx_in;
    if (is_hit) begin
      p_nxt.hit      = 1'b1;
      p_nxt.hit_data = data_r;
      p_nxt.hit_cnt  = cnt_r;
      hit_idx_nxt    = MY_IDX;
    end
    if (is_vic) begin
      p_nxt.vic_ok    = 1'b1;
      p_nxt.vic_cnt   = cnt_r;
      p_nxt.vic_stamp = stamp_r;
      vic_idx_nxt     = MY_IDX;
    end
    if (is_free) begin
      p_nxt.free_ok = 1'b1;
      free_idx_nxt  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.act <= 1'b0;
    end else begin
      p_r.act <= p_nxt.act;
    end
    p_r.mode      <= p_nxt.mode;
    p_r.key       <= p_nxt.key;
    p_r.wdata     <= p_nxt.wdata;
    p_r.hit       <= p_nxt.hit;
    p_r.hit_data  <= p_nxt.hit_data;
    p_r.hit_cnt   <= p_nxt.hit_cnt;
    p_r.vic_ok    <= p_nxt.vic_ok;
    p_r.vic_cnt   <= p_nxt.vic_cnt;
    p_r.vic_stamp <= p_nxt.vic_stamp;
    p_r.free_ok   <= p_nxt.free_ok;
    hit_idx_r     <= hit_idx_nxt;
    vic_idx_r     <= vic_idx_nxt;
    free_idx_r    <= free_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (upd.en && upd.evict && ev_idx == MY_IDX) valid_r <= 1'b0;
      if (upd.en && upd.ins && wr_idx == MY_IDX) valid_r <= 1'b1;
    end
    if (upd.en && wr_idx == MY_IDX) begin
      if (upd.ins) key_r <= upd.key;
      if (upd.upd_data) data_r <= upd.data;
      if (upd.upd_cnt) begin
        cnt_r   <= upd.count;
        stamp_r <= upd.stamp;
      end
    end
  end

  assign p_out        = p_r;
  assign hit_idx_out  = hit_idx_r;
  assign vic_idx_out  = vic_idx_r;
  assign free_idx_out = free_idx_r;

endmodule
